// ----- sv/mrq_pkg.sv -----
// ----------------------------------------------------------------------------
// mrq_pkg
// shared constants, types and helpers of the multilevel ready queue
// ----------------------------------------------------------------------------
package mrq_pkg;

   localparam int MAX_TASKS = 64;
   localparam int TIME_BITS = 48;
   localparam int NUM_LEVELS = 3;

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int RDY_DEPTH = NUM_LEVELS * MAX_TASKS;
   localparam int RDY_AW = $clog2(RDY_DEPTH);
   localparam int WENT_W = TIME_BITS + 8;
   localparam int FQ_DEPTH = 2;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      OP_ENQ   = 2'd0,
      OP_BLOCK = 2'd1,
      OP_REL   = 2'd2,
      OP_DEQ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADLVL = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type     op;
      logic [5:0] tid;
      logic [1:0] level;
      logic       lvl_bad;
      logic [1:0] q;
      time_type   wake;
      time_type   now;
   } cmd_type;

   // one entry of the wake list
   typedef struct packed {
      time_type   wtime;
      logic [5:0] tid;
      logic [1:0] level;
   } went_type;

   typedef struct packed {
      logic [5:0] tid;
      logic [1:0] level;
      logic       vres;
      status_type status;
      logic       last;
   } rsp_type;

   // circular index add, a < MAX_TASKS and b <= MAX_TASKS
   function automatic idx_type wrap_add(idx_type a, cnt_type b);
      logic [CNT_W:0] s;
      s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
      if (s >= (CNT_W + 1)'(MAX_TASKS)) begin
         s = s - (CNT_W + 1)'(MAX_TASKS);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

// ----- sv/mrq_req_if.sv -----
// ----------------------------------------------------------------------------
// mrq_req_if
// request channel carrying one command word
// ----------------------------------------------------------------------------
interface mrq_req_if import mrq_pkg::*;;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [5:0] task_id;
   logic [1:0] level;
   time_type   wake_time;
   time_type   now_time;

   modport source(output valid, op, task_id, level, wake_time, now_time, input ready);
   modport sink(input valid, op, task_id, level, wake_time, now_time, output ready);
endinterface

// ----- sv/mrq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mrq_rsp_if
// response channel carrying one result word
// ----------------------------------------------------------------------------
interface mrq_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] out_task;
   logic [1:0] out_level;
   logic       valid_res;
   logic [1:0] status;
   logic       last;

   modport source(output valid, out_task, out_level, valid_res, status, last, input ready);
   modport sink(input valid, out_task, out_level, valid_res, status, last, output ready);
endinterface

// ----- sv/mrq_ram.sv -----
// ----------------------------------------------------------------------------
// mrq_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module mrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/mrq_front.sv -----
// ----------------------------------------------------------------------------
// mrq_front
// accepts request words, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module mrq_front import mrq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   mrq_req_if.sink  req_ch,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_ready
);
   localparam int FQ_AW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int FQ_CW = $clog2(FQ_DEPTH + 1);

   cmd_type             slot_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FQ_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0]    count_ff, count_in;
   cmd_type             new_cmd;
   logic                push, pop;

   // classify the incoming word
   always_comb begin
      new_cmd.op      = op_type'(req_ch.op);
      new_cmd.tid     = req_ch.task_id;
      new_cmd.level   = req_ch.level;
      new_cmd.lvl_bad = (req_ch.level == 2'd0);
      new_cmd.q       = req_ch.level - 2'd1;
      new_cmd.wake    = req_ch.wake_time;
      new_cmd.now     = req_ch.now_time;
   end

   assign req_ch.ready = (count_ff != FQ_CW'(FQ_DEPTH));
   assign push = req_ch.valid && req_ch.ready;
   assign cmd_valid = (count_ff != '0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule

// ----- sv/mrq_back.sv -----
// ----------------------------------------------------------------------------
// mrq_back
// carries out queued commands on the ready queues and the sorted wake list
// ----------------------------------------------------------------------------
module mrq_back import mrq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_ready,
   mrq_rsp_if.source rsp_ch
);
   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_DEQ_OUT, S_INS_CMP, S_INS_PUT,
      S_REL_CMP, S_REL_END, S_REL_FULL
   } state_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   cnt_type    wcount_ff, wcount_in;
   idx_type    whead_ff, whead_in;
   cnt_type    pos_ff, pos_in;
   idx_type    rhead_ff [NUM_LEVELS];
   idx_type    rhead_in [NUM_LEVELS];
   idx_type    rtail_ff [NUM_LEVELS];
   idx_type    rtail_in [NUM_LEVELS];
   cnt_type    rcnt_ff [NUM_LEVELS];
   cnt_type    rcnt_in [NUM_LEVELS];
   logic       rel_any_ff, rel_any_in;
   logic [5:0] pend_tid_ff, pend_tid_in;
   logic [1:0] pend_lvl_ff, pend_lvl_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic                w_we, w_re;
   idx_type             w_waddr, w_raddr;
   went_type            w_wdata, w_rdata;
   logic [WENT_W-1:0]   w_rdata_raw;
   logic                r_we, r_re;
   logic [RDY_AW-1:0]   r_waddr, r_raddr;
   logic [5:0]          r_wdata, r_rdata;

   logic       out_free;
   logic [1:0] eq;
   logic       due, movable;

   mrq_ram #(.WIDTH(WENT_W), .DEPTH(MAX_TASKS)) u_wake_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
      .rd_en(w_re), .rd_addr(w_raddr), .rd_data(w_rdata_raw)
   );
   assign w_rdata = went_type'(w_rdata_raw);

   mrq_ram #(.WIDTH(6), .DEPTH(RDY_DEPTH)) u_ready_ram (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
      .rd_en(r_re), .rd_addr(r_raddr), .rd_data(r_rdata)
   );

   function automatic logic [RDY_AW-1:0] rdy_addr(logic [1:0] q, idx_type p);
      return RDY_AW'(q) * RDY_AW'(MAX_TASKS) + RDY_AW'(p);
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_ready = (state_ff == S_IDLE);
   assign eq = w_rdata.level - 2'd1;
   assign due = (w_rdata.wtime <= cmd_ff.now);
   assign movable = (w_rdata.level != 2'd0) && (rcnt_ff[eq] != CNT_W'(MAX_TASKS));

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      wcount_in = wcount_ff;
      whead_in = whead_ff;
      pos_in = pos_ff;
      rhead_in = rhead_ff;
      rtail_in = rtail_ff;
      rcnt_in = rcnt_ff;
      rel_any_in = rel_any_ff;
      pend_tid_in = pend_tid_ff;
      pend_lvl_in = pend_lvl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in = rsp_ff;
      w_we = 1'b0;
      w_re = 1'b0;
      w_waddr = whead_ff;
      w_raddr = whead_ff;
      w_wdata = '{wtime: cmd_ff.wake, tid: cmd_ff.tid, level: cmd_ff.level};
      r_we = 1'b0;
      r_re = 1'b0;
      r_waddr = rdy_addr(cmd_ff.q, rtail_ff[cmd_ff.q]);
      r_raddr = rdy_addr(cmd_ff.q, rhead_ff[cmd_ff.q]);
      r_wdata = cmd_ff.tid;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (cmd_ff.op)
                  OP_ENQ: begin
                     rsp_valid_in = 1'b1;
                     if (cmd_ff.lvl_bad) begin
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_BADLVL, 1'b1};
                     end else if (rcnt_ff[cmd_ff.q] == CNT_W'(MAX_TASKS)) begin
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_FULL, 1'b1};
                     end else begin
                        r_we = 1'b1;
                        rtail_in[cmd_ff.q] = wrap_add(rtail_ff[cmd_ff.q], CNT_W'(1));
                        rcnt_in[cmd_ff.q] = rcnt_ff[cmd_ff.q] + 1'b1;
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_OK, 1'b1};
                     end
                  end
                  OP_BLOCK: begin
                     if (cmd_ff.lvl_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_BADLVL, 1'b1};
                     end else if (wcount_ff == CNT_W'(MAX_TASKS)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_FULL, 1'b1};
                     end else if (wcount_ff == '0) begin
                        pos_in = '0;
                        state_in = S_INS_PUT;
                     end else begin
                        w_re = 1'b1;
                        w_raddr = wrap_add(whead_ff, wcount_ff - 1'b1);
                        pos_in = wcount_ff;
                        state_in = S_INS_CMP;
                     end
                  end
                  OP_REL: begin
                     if (wcount_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_EMPTY, 1'b1};
                     end else begin
                        w_re = 1'b1;
                        rel_any_in = 1'b0;
                        state_in = S_REL_CMP;
                     end
                  end
                  default: begin
                     if (cmd_ff.lvl_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_BADLVL, 1'b1};
                     end else if (rcnt_ff[cmd_ff.q] == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{6'd0, 2'd0, 1'b0, ST_EMPTY, 1'b1};
                     end else begin
                        r_re = 1'b1;
                        rhead_in[cmd_ff.q] = wrap_add(rhead_ff[cmd_ff.q], CNT_W'(1));
                        rcnt_in[cmd_ff.q] = rcnt_ff[cmd_ff.q] - 1'b1;
                        state_in = S_DEQ_OUT;
                     end
                  end
               endcase
            end
         end
         S_DEQ_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{r_rdata, cmd_ff.level, 1'b1, ST_OK, 1'b1};
               state_in = S_IDLE;
            end
         end
         S_INS_CMP: begin
            // shift one later entry up per cycle, equal times stay in front
            if (w_rdata.wtime > cmd_ff.wake) begin
               w_we = 1'b1;
               w_waddr = wrap_add(whead_ff, pos_ff);
               w_wdata = w_rdata;
               pos_in = pos_ff - 1'b1;
               if (pos_ff == CNT_W'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  w_re = 1'b1;
                  w_raddr = wrap_add(whead_ff, pos_ff - CNT_W'(2));
               end
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            if (out_free) begin
               w_we = 1'b1;
               w_waddr = wrap_add(whead_ff, pos_ff);
               wcount_in = wcount_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = '{6'd0, 2'd0, 1'b0, ST_OK, 1'b1};
               state_in = S_IDLE;
            end
         end
         S_REL_CMP: begin
            // a moved entry is held until the next one tells whether it is last
            if (out_free) begin
               if (due && movable) begin
                  r_we = 1'b1;
                  r_waddr = rdy_addr(eq, rtail_ff[eq]);
                  r_wdata = w_rdata.tid;
                  rtail_in[eq] = wrap_add(rtail_ff[eq], CNT_W'(1));
                  rcnt_in[eq] = rcnt_ff[eq] + 1'b1;
                  whead_in = wrap_add(whead_ff, CNT_W'(1));
                  wcount_in = wcount_ff - 1'b1;
                  if (rel_any_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{pend_tid_ff, pend_lvl_ff, 1'b1, ST_OK, 1'b0};
                  end
                  rel_any_in = 1'b1;
                  pend_tid_in = w_rdata.tid;
                  pend_lvl_in = w_rdata.level;
                  if (wcount_ff == CNT_W'(1)) begin
                     state_in = S_REL_END;
                  end else begin
                     w_re = 1'b1;
                     w_raddr = wrap_add(whead_ff, CNT_W'(1));
                  end
               end else if (due) begin
                  rsp_valid_in = 1'b1;
                  if (rel_any_ff) begin
                     rsp_in = '{pend_tid_ff, pend_lvl_ff, 1'b1, ST_OK, 1'b0};
                     state_in = S_REL_FULL;
                  end else begin
                     rsp_in = '{6'd0, 2'd0, 1'b0, ST_FULL, 1'b1};
                     state_in = S_IDLE;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  if (rel_any_ff) begin
                     rsp_in = '{pend_tid_ff, pend_lvl_ff, 1'b1, ST_OK, 1'b1};
                  end else begin
                     rsp_in = '{6'd0, 2'd0, 1'b0, ST_EMPTY, 1'b1};
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_REL_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{pend_tid_ff, pend_lvl_ff, 1'b1, ST_OK, 1'b1};
               state_in = S_IDLE;
            end
         end
         S_REL_FULL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{6'd0, 2'd0, 1'b0, ST_FULL, 1'b1};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      pos_ff <= pos_in;
      pend_tid_ff <= pend_tid_in;
      pend_lvl_ff <= pend_lvl_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= S_IDLE;
         wcount_ff <= '0;
         whead_ff <= '0;
         rel_any_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            rhead_ff[i] <= '0;
            rtail_ff[i] <= '0;
            rcnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         wcount_ff <= wcount_in;
         whead_ff <= whead_in;
         rel_any_ff <= rel_any_in;
         rsp_valid_ff <= rsp_valid_in;
         rhead_ff <= rhead_in;
         rtail_ff <= rtail_in;
         rcnt_ff <= rcnt_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_task = rsp_ff.tid;
   assign rsp_ch.out_level = rsp_ff.level;
   assign rsp_ch.valid_res = rsp_ff.vres;
   assign rsp_ch.status = rsp_ff.status;
   assign rsp_ch.last = rsp_ff.last;
endmodule

// ----- sv/multilevel_ready_queue_with_wake_list.sv -----
// ----------------------------------------------------------------------------
// multilevel_ready_queue_with_wake_list
// three fifo ready queues plus a wake list sorted by wake time
// ----------------------------------------------------------------------------
// usage
//   req_ch takes one command word per handshake: ready enqueue, block,
//   release or dequeue. rsp_ch returns result words; last marks the final
//   word of each command. release returns one word per moved task, plus
//   a full-status word when a due task then meets a full queue, or only a
//   status word when no task moves.
// command queue and pacing
//   a two-word command queue sits between the front end and the back end,
//   so requests are taken while a result waits on rsp_ch
//   the back end takes a new command only in its idle state, so it
//   carries out one command at a time; release moves due tasks in wake
//   order, block shifts later entries up one at a time from the tail
//   while they wake after the new task, then writes the new entry
//   a single back-end sequencer drives one read and one write port on
//   each memory (registered reads)
// reset
//   synchronous, clears queue counts, pointers and the wake count; the
//   memories keep their contents, unused slots are never read
// stall
//   when rsp_ch is not ready the back end waits before each result word and
//   the command queue fills, then req_ch.ready drops
// ----------------------------------------------------------------------------
module multilevel_ready_queue_with_wake_list import mrq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mrq_req_if.sink   req_ch,
   mrq_rsp_if.source rsp_ch
);
   // classified command between front and back
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   mrq_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
   );

   mrq_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready),
      .rsp_ch(rsp_ch)
   );

   // a reported task always has ok status and a real level
   a_task_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.valid_res) |-> (rsp_ch.status == ST_OK && rsp_ch.out_level != 2'd0))
      else $error("reported task with bad status or level");

   // words without a task carry zero task and level
   a_no_task_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.valid_res) |-> (rsp_ch.out_task == 6'd0 && rsp_ch.out_level == 2'd0))
      else $error("non-task word carries task fields");

   // a status word without a task always ends its command
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.valid_res) |-> rsp_ch.last)
      else $error("status word not marked last");
endmodule
